/* rtl/flt_pkg.sv */
package flt_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
    localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [7:0] ChOpenBrace  = 8'h7B;
    localparam logic [7:0] ChCloseBrace = 8'h7D;
    localparam logic [7:0] ChQuote      = 8'h22;
    localparam logic [7:0] ChColon      = 8'h3A;
    localparam logic [7:0] ChComma      = 8'h2C;
    localparam logic [7:0] ChSpace      = 8'h20;
    localparam logic [7:0] ChLowerN     = 8'h6E;

    typedef enum logic [3:0] {
        PH_OPEN   = 4'd0,
        PH_NAMEQ  = 4'd1,
        PH_NAME   = 4'd2,
        PH_COLON  = 4'd3,
        PH_VALUE  = 4'd4,
        PH_STRING = 4'd5,
        PH_NULL   = 4'd6,
        PH_NEXT   = 4'd7,
        PH_DONE   = 4'd8,
        PH_FAIL   = 4'd9
    } t_phase;

    typedef enum logic [2:0] {
        TK_NAME_BYTE  = 3'd0,
        TK_NAME_END   = 3'd1,
        TK_VALUE_BYTE = 3'd2,
        TK_VALUE_END  = 3'd3,
        TK_NULL       = 3'd4,
        TK_COMPLETE   = 3'd5,
        TK_MALFORMED  = 3'd6
    } t_token_kind;

    typedef struct packed {
        t_token_kind kind;
        logic [7:0]  ch;
        logic        run_end;
    } t_token;

    // Letters of the null literal, indexed by how many have matched.
    function automatic logic [7:0] null_letter(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h6E;
            2'd1:    ch = 8'h75;
            2'd2:    ch = 8'h6C;
            2'd3:    ch = 8'h6C;
            default: ch = 8'h6C;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/flt_outq.sv */
module flt_outq
    import flt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_wr_n,
    input  t_token     i_wr0,
    input  t_token     i_wr1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_token     o_token
);

    t_token                r_mem [QueueDepth];
    logic [QueuePtrW-1:0]  r_wp;
    logic [QueuePtrW-1:0]  r_rp;
    logic [QueueCntW-1:0]  r_count;
    logic [QueuePtrW-1:0]  n_wp;
    logic [QueuePtrW-1:0]  n_rp;
    logic [QueueCntW-1:0]  n_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rp];
    // Room for the worst case of two tokens from one byte.
    assign o_room  = (r_count <= QueueCntW'(QueueDepth - 2));
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wp    = r_wp + QueuePtrW'(i_wr_n);
        n_rp    = r_rp + QueuePtrW'(pop);
        n_count = r_count + QueueCntW'(i_wr_n) - QueueCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_n != 2'd0) begin
            r_mem[r_wp] <= i_wr0;
        end
        if (i_wr_n == 2'd2) begin
            r_mem[r_wp + QueuePtrW'(1)] <= i_wr1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QueueCntW'(QueueDepth))
        else $error("output queue count beyond depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_n != 2'd0) |-> (r_count <= QueueCntW'(QueueDepth - 2)))
        else $error("output queue written without room");

    a_pointer_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QueueCntW'(QueueDepth)) |-> (r_wp == r_rp))
        else $error("output queue pointers out of step with count");

endmodule

/* rtl/flat_json_object_tokenizer.sv */
// Tokenizer for one flat JSON object, one character per transaction on the
// input stream (tlast on the final character). Each character is parsed in
// the cycle it is accepted and gives zero, one or two tokens, which go into a
// four-entry output queue, where they are registered, and leave on the output
// stream one per cycle while tready is high. A character is taken every
// cycle while the queue has two free entries; only a downstream stall or a
// run of two-token characters (final byte of an unclosed object) holds
// tready low. Token kind travels on tuser, the character on tdata, and tlast
// marks the last token of one input character.
module flat_json_object_tokenizer
    import flt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] byte_value
    input  logic       i_s_tlast,   // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] token_byte
    output logic [2:0] o_m_tuser,   // [2:0] token_kind
    output logic       o_m_tlast    // run_end
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [1:0] r_null_cnt;
    logic [1:0] n_null_cnt;

    logic       accept;
    logic       tok_a_v;
    logic       tok_b_v;
    t_token     tok_a;
    t_token     tok_b;
    logic [1:0] wr_n;
    t_token     wr0;
    t_token     wr1;
    logic       q_room;
    logic       q_valid;
    t_token     q_token;
    logic [7:0] ch;

    assign ch     = i_s_tdata;
    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = q_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_OPEN;
            r_null_cnt <= 2'd0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_null_cnt <= n_null_cnt;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_null_cnt = r_null_cnt;
        tok_a_v    = 1'b0;
        tok_a      = '{kind: TK_MALFORMED, ch: 8'd0, run_end: 1'b0};
        tok_b_v    = 1'b0;
        tok_b      = '{kind: TK_MALFORMED, ch: 8'd0, run_end: 1'b1};

        case (r_phase)
            PH_OPEN: begin
                if (ch == ChOpenBrace) begin
                    n_phase = PH_NAMEQ;
                end else if (ch != ChSpace) begin
                    n_phase = PH_FAIL;
                    tok_a_v = 1'b1;
                end
            end
            PH_NAMEQ: begin
                if (ch == ChQuote) begin
                    n_phase = PH_NAME;
                end else if (ch != ChSpace) begin
                    n_phase = PH_FAIL;
                    tok_a_v = 1'b1;
                end
            end
            PH_NAME: begin
                tok_a_v = 1'b1;
                if (ch == ChQuote) begin
                    n_phase    = PH_COLON;
                    tok_a.kind = TK_NAME_END;
                end else begin
                    tok_a.kind = TK_NAME_BYTE;
                    tok_a.ch   = ch;
                end
            end
            PH_COLON: begin
                if (ch == ChColon) begin
                    n_phase = PH_VALUE;
                end else if (ch != ChSpace) begin
                    n_phase = PH_FAIL;
                    tok_a_v = 1'b1;
                end
            end
            PH_VALUE: begin
                if (ch == ChQuote) begin
                    n_phase = PH_STRING;
                end else if (ch == ChLowerN) begin
                    n_phase    = PH_NULL;
                    n_null_cnt = 2'd1;
                end else if (ch != ChSpace) begin
                    n_phase = PH_FAIL;
                    tok_a_v = 1'b1;
                end
            end
            PH_STRING: begin
                tok_a_v = 1'b1;
                if (ch == ChQuote) begin
                    n_phase    = PH_NEXT;
                    tok_a.kind = TK_VALUE_END;
                end else begin
                    tok_a.kind = TK_VALUE_BYTE;
                    tok_a.ch   = ch;
                end
            end
            PH_NULL: begin
                if (ch == null_letter(r_null_cnt)) begin
                    if (r_null_cnt == 2'd3) begin
                        n_phase    = PH_NEXT;
                        n_null_cnt = 2'd0;
                        tok_a_v    = 1'b1;
                        tok_a.kind = TK_NULL;
                    end else begin
                        n_null_cnt = r_null_cnt + 2'd1;
                    end
                end else begin
                    n_phase    = PH_FAIL;
                    n_null_cnt = 2'd0;
                    tok_a_v    = 1'b1;
                end
            end
            PH_NEXT: begin
                if (ch == ChComma) begin
                    n_phase = PH_NAMEQ;
                end else if (ch == ChCloseBrace) begin
                    n_phase    = PH_DONE;
                    tok_a_v    = 1'b1;
                    tok_a.kind = TK_COMPLETE;
                end else if (ch != ChSpace) begin
                    n_phase = PH_FAIL;
                    tok_a_v = 1'b1;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_FAIL;
            end
        endcase

        // Final character: flag an unclosed object, then start over.
        if (i_s_tlast) begin
            if (n_phase != PH_DONE && n_phase != PH_FAIL) begin
                tok_b_v = 1'b1;
            end
            n_phase    = PH_OPEN;
            n_null_cnt = 2'd0;
        end
        tok_a.run_end = !tok_b_v;
    end

    always_comb begin
        wr_n = 2'd0;
        wr0  = tok_a;
        wr1  = tok_b;
        if (accept) begin
            wr_n = 2'(tok_a_v) + 2'(tok_b_v);
            if (!tok_a_v) begin
                wr0 = tok_b;
            end
        end
    end

    flt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_n  (wr_n),
        .i_wr0   (wr0),
        .i_wr1   (wr1),
        .o_room  (q_room),
        .o_valid (q_valid),
        .i_ready (i_m_tready),
        .o_token (q_token)
    );

    assign o_m_tvalid = q_valid;
    assign o_m_tdata  = q_token.ch;
    assign o_m_tuser  = q_token.kind;
    assign o_m_tlast  = q_token.run_end;

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_tlast) |=> (r_phase == PH_OPEN && r_null_cnt == 2'd0))
        else $error("parser did not restart after final character");

    a_null_cnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_null_cnt != 2'd0) |-> (r_phase == PH_NULL))
        else $error("null letter count live outside null literal");

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_s_tlast && (r_phase == PH_DONE || r_phase == PH_FAIL))
            |-> (wr_n == 2'd0))
        else $error("token emitted after object closed or failed");

endmodule
